// File: hw/rtl/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types, register indexes and helpers for the Bayer channel averager.
// ----------------------------------------------------------------------------
package bca_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_EXCLUDED_ROWS = 3'd2;
   localparam logic [2:0] REG_GRAY_MODE     = 3'd3;
   localparam logic [2:0] REG_FRAME_COUNT   = 3'd4;

   // Gray decoding modes
   localparam logic [1:0] GRAY_RAW         = 2'd0;
   localparam logic [1:0] GRAY_DECODE      = 2'd1;
   localparam logic [1:0] GRAY_DECODE_KEEP = 2'd2;

   localparam logic [15:0] GRAY_MASK = 16'h03FF;
   localparam logic [15:0] GRAY_KEEP = 16'd1023;

   // Bayer lanes, indexed by {odd_row, odd_col}
   localparam int LANES    = 4;
   localparam int LANE_B   = 0;
   localparam int LANE_GB  = 1;
   localparam int LANE_GR  = 2;
   localparam int LANE_R   = 3;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [11:0] excluded_rows;
      logic [1:0]  gray_mode;
      logic [7:0]  frame_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIVIDE,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic mul_a;
      logic mul_b;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic frame_end;
      logic div_last;
   } dp_status_type;

   // 10-bit Gray to binary: each bit is the XOR of itself and all higher bits
   function automatic logic [15:0] gray_to_binary(input logic [15:0] raw);
      logic [9:0] g;
      logic [9:0] b;
      g = raw[9:0] & GRAY_MASK[9:0];
      b = '0;
      for (int i = 0; i < 10; i++) begin
         for (int j = 0; j < 10; j++) begin
            if (j >= i) begin
               b[i] = b[i] ^ g[j];
            end
         end
      end
      return {6'd0, b};
   endfunction

endpackage

// File: hw/rtl/bayer_channel_average.sv
// ----------------------------------------------------------------------------
// bayer_channel_average
// Per-channel means of a Bayer raster frame, with optional Gray decoding.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one per cycle while
// req_stall is low. Each active pixel is summed into one of four saturating
// Bayer accumulators (B, Gb, Gr, R) chosen by row and column parity.
// The last pixel of a frame starts the end-of-frame sequence: ST_MUL_A and
// ST_MUL_B build the divisor (half width times half active rows, then times
// frame_count), ST_DIVIDE runs a restoring divide on all four sums in
// parallel, one quotient bit per cycle, and ST_DONE loads the result
// register. req_stall stays high from the last pixel until that load.
// The result register holds while rsp_stall is high; a new frame streams in
// meanwhile, and the next result waits only if the previous one is still
// held. Configuration is written through csr_ while the block is idle.
// The block itself does not enforce this; the user is bound to it.
// Reset restores the register defaults, clears the sums and positions,
// and drops rsp_valid.
// ----------------------------------------------------------------------------
module bayer_channel_average #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int SUM_WIDTH  = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_red_average,
   output logic [15:0] rsp_gr_average,
   output logic [15:0] rsp_gb_average,
   output logic [15:0] rsp_blue_average
);

   bca_pkg::cfg_type       cfg_ff;
   bca_pkg::dp_cmd_type    cmd;
   bca_pkg::dp_status_type status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 13'd640;
         cfg_ff.image_height  <= 13'd480;
         cfg_ff.excluded_rows <= 12'd80;
         cfg_ff.gray_mode     <= bca_pkg::GRAY_RAW;
         cfg_ff.frame_count   <= 8'd1;
      end else if (csr_wen) begin
         case (csr_index)
            bca_pkg::REG_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_wdata;
            bca_pkg::REG_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_wdata;
            bca_pkg::REG_EXCLUDED_ROWS: cfg_ff.excluded_rows <= csr_wdata[11:0];
            bca_pkg::REG_GRAY_MODE:     cfg_ff.gray_mode     <= csr_wdata[1:0];
            bca_pkg::REG_FRAME_COUNT:   cfg_ff.frame_count   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   bca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bca_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_pixel        (req_pixel),
      .cmd              (cmd),
      .status           (status),
      .rsp_red_average  (rsp_red_average),
      .rsp_gr_average   (rsp_gr_average),
      .rsp_gb_average   (rsp_gb_average),
      .rsp_blue_average (rsp_blue_average)
   );

endmodule

// File: hw/rtl/bca_ctrl.sv
// ----------------------------------------------------------------------------
// bca_ctrl
// Sequencer: streams pixels, then runs divisor build, division and output load.
// ----------------------------------------------------------------------------
module bca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bca_pkg::dp_status_type status,
   output bca_pkg::dp_cmd_type    cmd
);

   bca_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bca_pkg::ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bca_pkg::ST_RUN: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.frame_end) begin
                  state_in = bca_pkg::ST_MUL_A;
               end
            end
         end
         bca_pkg::ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = bca_pkg::ST_MUL_B;
         end
         bca_pkg::ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = bca_pkg::ST_DIVIDE;
         end
         bca_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bca_pkg::ST_DONE;
            end
         end
         bca_pkg::ST_DONE: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bca_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = bca_pkg::ST_RUN;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/bca_datapath.sv
// ----------------------------------------------------------------------------
// bca_datapath
// Raster counters, Bayer accumulators, divisor multiplier and four-lane
// restoring divider with output registers.
// ----------------------------------------------------------------------------
module bca_datapath #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int SUM_WIDTH  = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bca_pkg::cfg_type       cfg,
   input  logic [15:0]            req_pixel,
   input  bca_pkg::dp_cmd_type    cmd,
   output bca_pkg::dp_status_type status,
   output logic [15:0]            rsp_red_average,
   output logic [15:0]            rsp_gr_average,
   output logic [15:0]            rsp_gb_average,
   output logic [15:0]            rsp_blue_average
);

   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int RB  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int WH  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = (WW > 13) ? WW : 13;
   localparam int CH  = (WH > 13) ? WH : 13;
   localparam int AH  = (WH > 12) ? WH : 12;
   localparam int HWB = WW - 1;
   localparam int HHB = WH - 1;
   localparam int DB  = HWB + HHB + 8;
   localparam int DCW = $clog2(SUM_WIDTH);

   logic [CB-1:0]        col_ff, col_in;
   logic [RB-1:0]        row_ff, row_in;
   logic [SUM_WIDTH-1:0] acc_ff [bca_pkg::LANES];
   logic [SUM_WIDTH-1:0] acc_in [bca_pkg::LANES];
   logic [DB-1:0]        rem_ff [bca_pkg::LANES];
   logic [DB-1:0]        rem_in [bca_pkg::LANES];
   logic [15:0]          avg_ff [bca_pkg::LANES];
   logic [HWB+HHB-1:0]   prod_ff;
   logic [DB-1:0]        divisor_ff;
   logic [DCW-1:0]       div_cnt_ff;

   logic [CW-1:0]  w_ext;
   logic [CH-1:0]  h_ext;
   logic [WW-1:0]  w_cl;
   logic [WH-1:0]  h_cl;
   logic [AH-1:0]  act_wide;
   logic [WH-1:0]  active;
   logic [15:0]    px;
   logic           in_active;
   logic           row_end;
   logic           frame_end;
   logic [1:0]     lane;

   // Clamp geometry and derive the active row count
   always_comb begin
      w_ext = CW'(cfg.image_width);
      h_ext = CH'(cfg.image_height);
      if (w_ext > CW'(MAX_WIDTH)) begin
         w_cl = WW'(MAX_WIDTH);
      end else if (w_ext == '0) begin
         w_cl = WW'(1);
      end else begin
         w_cl = WW'(w_ext);
      end
      if (h_ext > CH'(MAX_HEIGHT)) begin
         h_cl = WH'(MAX_HEIGHT);
      end else if (h_ext == '0) begin
         h_cl = WH'(1);
      end else begin
         h_cl = WH'(h_ext);
      end
      if (AH'(cfg.excluded_rows) < AH'(h_cl)) begin
         act_wide = AH'(h_cl) - AH'(cfg.excluded_rows);
      end else begin
         act_wide = '0;
      end
      active = WH'(act_wide);
   end

   // Decode the pixel and place it in the raster
   always_comb begin
      if (cfg.gray_mode == bca_pkg::GRAY_DECODE ||
          (cfg.gray_mode == bca_pkg::GRAY_DECODE_KEEP && req_pixel != bca_pkg::GRAY_KEEP)) begin
         px = bca_pkg::gray_to_binary(req_pixel);
      end else begin
         px = req_pixel;
      end
      in_active = WH'(row_ff) < active;
      row_end   = ((CB+1)'(col_ff) + (CB+1)'(1)) >= (CB+1)'(w_cl);
      frame_end = row_end && (((RB+1)'(row_ff) + (RB+1)'(1)) >= (RB+1)'(h_cl));
      lane      = {row_ff[0], col_ff[0]};
      col_in    = col_ff;
      row_in    = row_ff;
      if (cmd.accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   assign status.frame_end = frame_end;
   assign status.div_last  = div_cnt_ff == DCW'(SUM_WIDTH - 1);

   // Per-lane accumulate and divide step
   always_comb begin
      logic [SUM_WIDTH:0] sum;
      logic [DB:0]        trial;
      for (int i = 0; i < bca_pkg::LANES; i++) begin
         acc_in[i] = acc_ff[i];
         rem_in[i] = rem_ff[i];
         sum   = (SUM_WIDTH+1)'(acc_ff[i]) + (SUM_WIDTH+1)'(px);
         trial = {rem_ff[i], acc_ff[i][SUM_WIDTH-1]};
         if (cmd.accept && in_active && lane == 2'(i)) begin
            acc_in[i] = sum[SUM_WIDTH] ? '1 : sum[SUM_WIDTH-1:0];
         end
         if (cmd.mul_b) begin
            rem_in[i] = '0;
         end
         if (cmd.div_step) begin
            // shift the dividend out, quotient bits in at the bottom
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in[i] = DB'(trial - {1'b0, divisor_ff});
               acc_in[i] = {acc_ff[i][SUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[DB-1:0];
               acc_in[i] = {acc_ff[i][SUM_WIDTH-2:0], 1'b0};
            end
         end
         if (cmd.load_out) begin
            acc_in[i] = '0;
         end
      end
   end

   // Control counters and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         div_cnt_ff <= '0;
         for (int i = 0; i < bca_pkg::LANES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         for (int i = 0; i < bca_pkg::LANES; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         if (cmd.mul_b) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DCW'(1);
         end
      end
   end

   // Divisor build, remainders and result payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < bca_pkg::LANES; i++) begin
         rem_ff[i] <= rem_in[i];
      end
      if (cmd.mul_a) begin
         prod_ff <= (HWB+HHB)'(w_cl >> 1) * (HWB+HHB)'(active >> 1);
      end
      if (cmd.mul_b) begin
         divisor_ff <= DB'(prod_ff) * DB'(cfg.frame_count);
      end
      if (cmd.load_out) begin
         for (int i = 0; i < bca_pkg::LANES; i++) begin
            if (divisor_ff == '0) begin
               avg_ff[i] <= '0;
            end else if (acc_ff[i][SUM_WIDTH-1:16] != '0) begin
               avg_ff[i] <= 16'hFFFF;
            end else begin
               avg_ff[i] <= acc_ff[i][15:0];
            end
         end
      end
   end

   assign rsp_red_average  = avg_ff[bca_pkg::LANE_R];
   assign rsp_gr_average   = avg_ff[bca_pkg::LANE_GR];
   assign rsp_gb_average   = avg_ff[bca_pkg::LANE_GB];
   assign rsp_blue_average = avg_ff[bca_pkg::LANE_B];

endmodule

// File: tb/bayer_channel_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_channel_average_test
// Self-checking bench for the Bayer channel averager.
// ----------------------------------------------------------------------------
// Streams raster frames of pixels into the block and keeps a cycle-free model
// of the four Bayer accumulators. Each frame end produces one expected set of
// channel means, and every result transfer is checked lane by lane against
// the oldest pending set. Directed tests cover register defaults, pixel and
// Gray decoding extremes, zero divisors, zero-size and resized geometry and a
// long output hold; random frames with random registers follow. Both sides
// idle in random bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module bayer_channel_average_test;

   localparam int          GEOM_LIMIT_W  = 4096;
   localparam int          GEOM_LIMIT_H  = 4096;
   localparam int          SUM_BITS      = 40;
   localparam longint unsigned SUM_CEILING = (64'd1 << SUM_BITS) - 64'd1;
   localparam int          SETTLE_CYCLES = SUM_BITS + 12;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          DRAIN_LIMIT   = 2000;
   localparam int          HOLD_CYCLES   = 300;
   localparam logic [1:0]  GRAY_UNDEFINED = 2'd3;
   localparam logic [2:0]  REG_SPARE      = 3'd7;

   // One expected or observed set of means, indexed by lane
   typedef logic [bca_pkg::LANES-1:0][15:0] channel_means_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        csr_wen   = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_red_average;
   logic [15:0] rsp_gr_average;
   logic [15:0] rsp_gb_average;
   logic [15:0] rsp_blue_average;

   // Shadow registers and accumulator state of the model
   bca_pkg::cfg_type   shadow_cfg;
   int unsigned        col_pos;
   int unsigned        row_pos;
   longint unsigned    lane_sum [bca_pkg::LANES];
   channel_means_type  expected_averages [$];

   string lane_names [bca_pkg::LANES] = '{"blue", "gb", "gr", "red"};

   // Run control and bookkeeping
   bit          sender_gaps      = 1'b1;
   bit          receiver_stalls  = 1'b1;
   int          long_hold_cycles = 0;
   int unsigned error_count      = 0;
   int unsigned pixels_sent      = 0;
   int unsigned frames_checked   = 0;
   int unsigned register_writes  = 0;

   bayer_channel_average dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_average  (rsp_red_average),
      .rsp_gr_average   (rsp_gr_average),
      .rsp_gb_average   (rsp_gb_average),
      .rsp_blue_average (rsp_blue_average)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------

   function automatic logic [15:0] decode_gray(input logic [15:0] raw);
      logic [9:0] bin;
      bin[9] = raw[9];
      for (int i = 8; i >= 0; i--) begin
         bin[i] = bin[i + 1] ^ raw[i];
      end
      return {6'd0, bin};
   endfunction

   function automatic void clear_frame_state();
      col_pos = 0;
      row_pos = 0;
      foreach (lane_sum[i]) lane_sum[i] = 0;
   endfunction

   // Accumulate one accepted pixel; queue the means when it closes a frame
   function automatic void account_pixel(input logic [15:0] raw);
      int unsigned       w;
      int unsigned       h;
      int unsigned       active;
      int unsigned       lane;
      logic [15:0]       value;
      longint unsigned   divisor;
      longint unsigned   quotient;
      channel_means_type means;
      bit                row_end;
      bit                frame_end;
      w = shadow_cfg.image_width;
      h = shadow_cfg.image_height;
      if (w > GEOM_LIMIT_W) w = GEOM_LIMIT_W;
      if (h > GEOM_LIMIT_H) h = GEOM_LIMIT_H;
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      active = (shadow_cfg.excluded_rows < h) ? h - shadow_cfg.excluded_rows : 0;

      value = raw;
      if (shadow_cfg.gray_mode == bca_pkg::GRAY_DECODE ||
          (shadow_cfg.gray_mode == bca_pkg::GRAY_DECODE_KEEP &&
           raw != bca_pkg::GRAY_KEEP)) begin
         value = decode_gray(raw);
      end

      // Saturating add into the lane picked by row and column parity
      if (row_pos < active) begin
         lane = (row_pos % 2) * 2 + (col_pos % 2);
         if (lane_sum[lane] > SUM_CEILING - value) begin
            lane_sum[lane] = SUM_CEILING;
         end else begin
            lane_sum[lane] += value;
         end
      end

      row_end   = (col_pos + 1 >= w);
      frame_end = row_end && (row_pos + 1 >= h);

      if (frame_end) begin
         divisor = 64'(w / 2) * 64'(active / 2) * 64'(shadow_cfg.frame_count);
         for (int k = 0; k < bca_pkg::LANES; k++) begin
            if (divisor == 0) begin
               means[k] = '0;
            end else begin
               quotient = lane_sum[k] / divisor;
               means[k] = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[15:0];
            end
         end
         expected_averages.insert(expected_averages.size(), means);
         clear_frame_state();
      end else if (row_end) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
   endfunction

   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return bca_pkg::GRAY_KEEP;
         3: return {6'($urandom), 10'h3FF};
         4: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one pixel and hold it until the transfer happens
   task automatic send_pixel(input logic [15:0] value);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      account_pixel(value);
      pixels_sent++;
   endtask

   // Send pixels until the model is back at the start of a frame
   task automatic send_frame(input int fill);
      do begin
         send_pixel((fill < 0) ? pick_pixel() : fill[15:0]);
      end while (col_pos != 0 || row_pos != 0);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every pending result, then let the divider settle
   task automatic quiesce();
      release_req();
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [12:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (index)
         bca_pkg::REG_IMAGE_WIDTH:   shadow_cfg.image_width   = value;
         bca_pkg::REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = value;
         bca_pkg::REG_EXCLUDED_ROWS: shadow_cfg.excluded_rows = value[11:0];
         bca_pkg::REG_GRAY_MODE:     shadow_cfg.gray_mode     = value[1:0];
         bca_pkg::REG_FRAME_COUNT:   shadow_cfg.frame_count   = value[7:0];
         default: ;
      endcase
      register_writes++;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned excluded, input logic [1:0] mode,
                               input int unsigned frames);
      quiesce();
      write_register(bca_pkg::REG_IMAGE_WIDTH, 13'(w));
      write_register(bca_pkg::REG_IMAGE_HEIGHT, 13'(h));
      write_register(bca_pkg::REG_EXCLUDED_ROWS, 13'(excluded));
      write_register(bca_pkg::REG_GRAY_MODE, {11'd0, mode});
      write_register(bca_pkg::REG_FRAME_COUNT, 13'(frames));
   endtask

   // ------------------------------------------------------------------
   // Result side: check each transfer, then decide the next stall
   // ------------------------------------------------------------------
   initial begin
      channel_means_type seen;
      channel_means_type want;
      int                stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen[bca_pkg::LANE_R]  = rsp_red_average;
            seen[bca_pkg::LANE_GR] = rsp_gr_average;
            seen[bca_pkg::LANE_GB] = rsp_gb_average;
            seen[bca_pkg::LANE_B]  = rsp_blue_average;
            if (expected_averages.size() == 0) begin
               report_mismatch("result transfer with no frame pending");
            end else begin
               want = expected_averages.pop_front();
               for (int k = 0; k < bca_pkg::LANES; k++) begin
                  if (seen[k] !== want[k]) begin
                     report_mismatch($sformatf("frame %0d %s_average: got %0d, expected %0d",
                                               frames_checked, lane_names[k], seen[k], want[k]));
                  end
               end
               frames_checked++;
            end
         end
         if (long_hold_cycles > 0) begin
            long_hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0 && receiver_stalls && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wen || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Only the width is changed, so height, excluded rows, Gray mode and
   // frame count run at their reset values
   task automatic test_register_defaults();
      quiesce();
      write_register(bca_pkg::REG_IMAGE_WIDTH, 13'd2);
      send_frame(-1);
   endtask

   task automatic test_pixel_extremes();
      set_geometry(2, 2, 0, bca_pkg::GRAY_DECODE_KEEP, 1);
      send_pixel(16'hFFFF);
      send_pixel(bca_pkg::GRAY_KEEP);
      send_pixel(16'h0000);
      send_pixel(16'h07FF);
      set_geometry(2, 2, 0, bca_pkg::GRAY_DECODE, 255);
      send_pixel(16'h03FF);
      send_pixel(16'h0200);
      send_pixel(16'hFFFF);
      send_pixel(16'h5555);
      set_geometry(2, 2, 0, GRAY_UNDEFINED, 1);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'h8000);
      send_pixel(16'h0001);
      set_geometry(2, 2, 0, bca_pkg::GRAY_RAW, 1);
      send_frame(16'hFFFF);
   endtask

   task automatic test_special_geometry();
      // width and height zero act as one: every pixel closes a frame
      set_geometry(0, 0, 0, bca_pkg::GRAY_RAW, 1);
      send_frame(-1);
      send_frame(-1);
      // odd width: quarter count truncates and the means clip at full scale
      set_geometry(3, 2, 0, bca_pkg::GRAY_RAW, 1);
      send_frame(16'hFFFF);
      // excluded rows not below the height
      set_geometry(2, 2, 4095, bca_pkg::GRAY_DECODE, 1);
      send_frame(-1);
      // odd active rows
      set_geometry(2, 3, 0, bca_pkg::GRAY_DECODE_KEEP, 3);
      send_frame(-1);
      // zero frame count
      set_geometry(2, 2, 0, bca_pkg::GRAY_RAW, 0);
      send_frame(-1);
      // shrink width and height in the middle of a row
      set_geometry(4, 4, 0, bca_pkg::GRAY_RAW, 1);
      send_pixel(pick_pixel());
      send_pixel(pick_pixel());
      quiesce();
      write_register(bca_pkg::REG_IMAGE_WIDTH, 13'd2);
      write_register(bca_pkg::REG_IMAGE_HEIGHT, 13'd2);
      send_frame(-1);
      // shrink the height below the current row
      set_geometry(2, 6, 0, bca_pkg::GRAY_RAW, 1);
      repeat (5) send_pixel(pick_pixel());
      quiesce();
      write_register(bca_pkg::REG_IMAGE_HEIGHT, 13'd2);
      write_register(REG_SPARE, 13'h1FFF);
      send_frame(-1);
   endtask

   // Hold the output long enough that the block fills and stalls its input
   task automatic test_output_hold();
      set_geometry(2, 2, 0, bca_pkg::GRAY_RAW, 1);
      sender_gaps = 1'b0;
      long_hold_cycles = HOLD_CYCLES;
      repeat (12) send_frame(-1);
      quiesce();
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_frames(input int unsigned pixel_budget, input bit with_idling);
      int unsigned first;
      int unsigned w;
      int unsigned h;
      int unsigned excluded;
      int unsigned frames;
      first = pixels_sent;
      while (pixels_sent - first < pixel_budget) begin
         if ($urandom_range(0, 4) != 0) begin
            w = 2 * $urandom_range(1, 6);
            h = 2 * $urandom_range(1, 4);
         end else begin
            w = $urandom_range(0, 13);
            h = $urandom_range(0, 9);
         end
         case ($urandom_range(0, 5))
            0:       excluded = $urandom_range(0, 4095);
            1, 2:    excluded = $urandom_range(0, h);
            default: excluded = 0;
         endcase
         frames = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 1;
         sender_gaps     = with_idling && ($urandom_range(0, 3) != 0);
         receiver_stalls = with_idling && ($urandom_range(0, 3) != 0);
         set_geometry(w, h, excluded, 2'($urandom_range(0, 3)), frames);
         repeat ($urandom_range(1, 3)) send_frame(-1);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      int waited;
      shadow_cfg.image_width   = 13'd640;
      shadow_cfg.image_height  = 13'd480;
      shadow_cfg.excluded_rows = 12'd80;
      shadow_cfg.gray_mode     = bca_pkg::GRAY_RAW;
      shadow_cfg.frame_count   = 8'd1;
      clear_frame_state();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_pixel_extremes();
      test_special_geometry();
      test_output_hold();
      test_random_frames(120, 1'b1);
      test_random_frames(50, 1'b0);

      // Drain with a bound, then give stray results time to show up
      release_req();
      waited = 0;
      while (expected_averages.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_averages.size() != 0) begin
         report_mismatch($sformatf("%0d frame results never arrived",
                                   expected_averages.size()));
      end

      $display("Summary: %0d pixels streamed, %0d frame results compared, %0d register writes",
               pixels_sent, frames_checked, register_writes);
      $display("Summary: all Gray modes, zero divisors, zero-size and resized geometry, output hold");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
